@@ hdl/ogesa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ogesa_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_POP   = 6'b000010,
    ST_REF   = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_GRANT = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;      // capture request stamp, clear reclaim count
    logic take_fresh;    // grant the next never-used slot
    logic take_pop;      // grant the free-list head, follow its link
    logic set_ref;       // capture the oldest slot's stamp as run reference
    logic reclaim;       // unlink oldest active slot, push it on the free list
    logic take_reclaim;  // grant the last reclaimed slot
    logic set_none;      // nothing to grant
    logic grant;         // commit the grant and load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic have_fresh;    // never-used slots remain
    logic have_free;     // free list not empty
    logic ring_empty;    // no active slot
    logic run_match;     // oldest active slot carries the reference stamp
    logic out_free;      // result register can take a new item
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/ogesa_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ogesa_dp #(
  parameter int unsigned SLOTS = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [ogesa_pkg::STAMP_W-1:0]    in_stamp,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [ogesa_pkg::SLOT_W-1:0]     out_slot,
  output logic [ogesa_pkg::COUNT_W-1:0]    out_reclaimed_count,
  input  ogesa_pkg::cmd_t                  cmd,
  output ogesa_pkg::sts_t                  sts
);
  import ogesa_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned IW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] SENT = IW'(SLOTS);

  // Link and stamp stores, slot-indexed only (sentinel links live in registers)
  logic [IW-1:0]      free_link_mem [SLOTS];
  logic [IW-1:0]      newer_mem     [SLOTS];
  logic [STAMP_W-1:0] stamp_mem     [SLOTS];

  logic [IW-1:0]      free_rd_r;
  logic [IW-1:0]      newer_rd_r;
  logic [STAMP_W-1:0] stamp_rd_r;

  // Control state
  logic [IW-1:0]      fresh_r;      // next never-used slot
  logic [IW-1:0]      free_head_r;  // free list head, SENT when empty
  logic [IW-1:0]      oldest_r;     // newer link of the sentinel
  logic [IW-1:0]      newest_r;     // older link of the sentinel
  logic               out_valid_r;

  // Per-item payload
  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] ref_r;
  logic [IW-1:0]      gslot_r;
  logic [IW-1:0]      prev_r;
  logic [COUNT_W-1:0] count_r;
  logic               nogrant_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [IW-1:0]      next_old;
  logic               commit;

  // Slot after the oldest; the newest has nothing newer
  assign next_old = (oldest_r == newest_r) ? SENT : newer_rd_r;
  assign commit   = cmd.grant && !nogrant_r;

  // Free link store: read at the free head, written on each push
  always_ff @(posedge clk) begin
    free_rd_r <= free_link_mem[free_head_r[AW-1:0]];
    if (cmd.reclaim) begin
      free_link_mem[oldest_r[AW-1:0]] <= free_head_r;
    end
  end

  // Newer link store: read at the oldest slot, newest gets the grant linked on
  always_ff @(posedge clk) begin
    newer_rd_r <= newer_mem[oldest_r[AW-1:0]];
    if (commit && (newest_r != SENT)) begin
      newer_mem[newest_r[AW-1:0]] <= gslot_r;
    end
  end

  // Stamp store: read at the oldest slot, written on grant
  always_ff @(posedge clk) begin
    stamp_rd_r <= stamp_mem[oldest_r[AW-1:0]];
    if (commit) begin
      stamp_mem[gslot_r[AW-1:0]] <= stamp_r;
    end
  end

  // List heads and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= '0;
      free_head_r <= SENT;
      oldest_r    <= SENT;
      newest_r    <= SENT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take_fresh) begin
        fresh_r <= fresh_r + 1'b1;
      end
      if (cmd.take_pop) begin
        free_head_r <= free_rd_r;
      end else if (cmd.reclaim) begin
        free_head_r <= oldest_r;
      end else if (cmd.take_reclaim) begin
        free_head_r <= prev_r;
      end
      if (cmd.reclaim) begin
        oldest_r <= next_old;
        if (next_old == SENT) begin
          newest_r <= SENT;
        end
      end else if (commit) begin
        if (newest_r == SENT) begin
          oldest_r <= gslot_r;
        end
        newest_r <= gslot_r;
      end
      if (cmd.grant) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      stamp_r   <= in_stamp;
      count_r   <= '0;
      nogrant_r <= cmd.set_none;
    end
    if (cmd.take_fresh) begin
      gslot_r <= fresh_r;
    end else if (cmd.take_pop || cmd.take_reclaim) begin
      gslot_r <= free_head_r;
    end
    if (cmd.set_ref) begin
      ref_r <= stamp_rd_r;
    end
    if (cmd.reclaim) begin
      prev_r  <= free_head_r;
      count_r <= count_r + 1'b1;
    end
    if (cmd.grant) begin
      out_slot_r  <= nogrant_r ? '0 : SLOT_W'(gslot_r);
      out_count_r <= count_r;
    end
  end

  // Status
  assign sts.have_fresh = (fresh_r != SENT);
  assign sts.have_free  = (free_head_r != SENT);
  assign sts.ring_empty = (oldest_r == SENT);
  assign sts.run_match  = (oldest_r != SENT) && (stamp_rd_r == ref_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_slot            = out_slot_r;
  assign out_reclaimed_count = out_count_r;

  // Sentinel links agree on whether the ring is empty
  a_ring_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r == SENT) == (newest_r == SENT))
    else $error("ring ends disagree on empty ring");

  // Reclaim only ever unlinks a real slot
  a_reclaim_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reclaim |-> (oldest_r != SENT))
    else $error("reclaim on empty ring");

  // A reclaim pass leaves at least one slot to grant
  a_reclaim_grant: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_reclaim |-> (free_head_r != SENT))
    else $error("reclaim grant from empty free list");

  // A grant shows a result on the next cycle
  a_grant_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> out_valid_r)
    else $error("grant without result");

endmodule
`default_nettype wire

@@ hdl/ogesa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ogesa_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  ogesa_pkg::sts_t    sts,
  output ogesa_pkg::cmd_t    cmd
);
  import ogesa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (sts.have_fresh) begin
            cmd.take_fresh = 1'b1;
            state_nxt      = ST_GRANT;
          end else if (sts.have_free) begin
            state_nxt = ST_POP;
          end else if (sts.ring_empty) begin
            cmd.set_none = 1'b1;
            state_nxt    = ST_GRANT;
          end else begin
            state_nxt = ST_REF;
          end
        end
      end
      ST_POP: begin
        cmd.take_pop = 1'b1;
        state_nxt    = ST_GRANT;
      end
      // oldest slot always goes; its stamp sets the run
      ST_REF: begin
        cmd.set_ref = 1'b1;
        cmd.reclaim = 1'b1;
        state_nxt   = ST_WAIT;
      end
      // store read of the new oldest slot
      ST_WAIT: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.run_match) begin
          cmd.reclaim = 1'b1;
          state_nxt   = ST_WAIT;
        end else begin
          cmd.take_reclaim = 1'b1;
          state_nxt        = ST_GRANT;
        end
      end
      ST_GRANT: begin
        if (sts.out_free) begin
          cmd.grant = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/oldest_group_evicting_slot_allocator.sv @@
// Flow: a never-used slot goes from IDLE straight to GRANT, a free-list pop
//   passes through POP, and k reclaimed oldest slots pass REF, then a WAIT
//   and CMP pair per slot (read, compare). A new item is taken only once the
//   last is granted; a held result stalls the grant.
// Reset: synchronous, active low; lists come up with all slots free in index
//   order, no clearing pass (unused slots are handed out by a counter).
`timescale 1ns / 1ps
`default_nettype none
module oldest_group_evicting_slot_allocator #(
  parameter int unsigned SLOTS = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [ogesa_pkg::STAMP_W-1:0]    in_stamp,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [ogesa_pkg::SLOT_W-1:0]     out_slot,
  output logic [ogesa_pkg::COUNT_W-1:0]    out_reclaimed_count
);
  import ogesa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ogesa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ogesa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_stamp            (in_stamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_slot            (out_slot),
    .out_reclaimed_count (out_reclaimed_count),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
`default_nettype wire

@@ dv/oldest_group_evicting_slot_allocator_tb.sv @@
`timescale 1ns / 1ps
module oldest_group_evicting_slot_allocator_tb;

  localparam int NSLOT = 256;
  localparam logic [8:0] SENT = 9'd256;   // ring sentinel, also "free list empty"
  localparam int NUM_ITEMS = 1700;
  localparam int CYCLE_LIMIT = 1000000;

  typedef logic [8:0] link_t;

  typedef struct {
    logic [ogesa_pkg::SLOT_W-1:0]  slot;
    logic [ogesa_pkg::COUNT_W-1:0] reclaimed;
  } grant_t;

  // Scoreboard: own copy of the free list and the age ring, plus pending grants
  class slot_grant_board;
    link_t        free_head;
    link_t        free_link[0:NSLOT-1];
    link_t        older_link[0:NSLOT];
    link_t        newer_link[0:NSLOT];
    logic [31:0]  slot_stamp[0:NSLOT-1];
    grant_t       pending_grants[$];
    int           error_count;

    function new();
      free_head = 9'd0;
      for (int i = 0; i < NSLOT; i++) begin
        free_link[i]  = link_t'(i + 1);
        older_link[i] = SENT;
        newer_link[i] = SENT;
        slot_stamp[i] = '0;
      end
      older_link[NSLOT] = SENT;
      newer_link[NSLOT] = SENT;
      error_count = 0;
    endfunction

    // Grant for one request, updating the lists
    function grant_t allocate(logic [31:0] stamp);
      grant_t      g;
      link_t       head, oldest, older, newer, s, newest;
      logic [31:0] run_stamp;
      logic [8:0]  count;
      count = '0;
      head  = free_head;
      // no free slot: reclaim the oldest group of equal stamps
      if (head == SENT) begin
        oldest = newer_link[SENT];
        if (oldest != SENT) begin
          run_stamp = slot_stamp[oldest];
          while (oldest != SENT && slot_stamp[oldest] == run_stamp) begin
            older = older_link[oldest];
            newer = newer_link[oldest];
            newer_link[older] = newer;
            older_link[newer] = older;
            older_link[oldest] = SENT;
            newer_link[oldest] = SENT;
            free_link[oldest]  = head;
            head   = oldest;
            count  = count + 1'b1;
            oldest = newer_link[SENT];
          end
        end
        free_head = head;
      end
      // both lists empty: not reachable from reset
      if (head == SENT) begin
        g.slot      = '0;
        g.reclaimed = count;
        return g;
      end
      // pop free head, link in as newest
      s = head;
      free_head     = free_link[s];
      free_link[s]  = SENT;
      slot_stamp[s] = stamp;
      newest = older_link[SENT];
      older_link[s] = newest;
      newer_link[s] = SENT;
      newer_link[newest] = s;
      older_link[SENT]   = s;
      g.slot      = s[7:0];
      g.reclaimed = count;
      return g;
    endfunction

    function void note_input(logic [31:0] stamp);
      pending_grants.push_back(allocate(stamp));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
    endtask

    task check_result(logic [7:0] slot, logic [8:0] reclaimed);
      grant_t g;
      if (pending_grants.size() == 0) begin
        report($sformatf("unexpected item slot=%0d reclaimed=%0d", slot, reclaimed));
      end else begin
        g = pending_grants.pop_front();
        if (slot !== g.slot)
          report($sformatf("slot got %0d want %0d", slot, g.slot));
        if (reclaimed !== g.reclaimed)
          report($sformatf("reclaimed_count got %0d want %0d", reclaimed, g.reclaimed));
      end
    endtask

    task check_drained();
      if (pending_grants.size() != 0)
        report($sformatf("%0d items never came out", pending_grants.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_stamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_slot;
  logic [8:0]  out_reclaimed_count;

  slot_grant_board board = new();

  oldest_group_evicting_slot_allocator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stamp            (in_stamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_slot            (out_slot),
    .out_reclaimed_count (out_reclaimed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_input(in_stamp);
    if (rst_n && out_valid && out_ready)
      board.check_result(out_slot, out_reclaimed_count);
  end

  // Result side backpressure: short stalls mostly, a few long, calm stretches
  int  stall_left = 0;
  int  ready_roll;
  bit  ready_calm = 1'b0;
  always @(posedge clk) begin
    ready_roll = $urandom_range(0, 999);
    if (ready_roll < 4)
      ready_calm <= !ready_calm;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!ready_calm) begin
        if (ready_roll < 150)
          stall_left <= $urandom_range(1, 3);
        else if (ready_roll < 180)
          stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Timeout
  int cycle_count = 0;
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  bit          send_calm = 1'b0;
  int          sent = 0;
  logic [31:0] ramp_stamp = '0;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_calm || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until taken, then sometimes idle a while
  task send_item(logic [31:0] stamp);
    int gap;
    in_valid <= 1'b1;
    in_stamp <= stamp;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stamps: random, corner values, or a slow ramp that often repeats
  function logic [31:0] pick_stamp();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h0000_0001;
          default: return 32'h8000_0000;
        endcase
      end
      1: begin
        ramp_stamp = ramp_stamp + $urandom_range(0, 3);
        return ramp_stamp;
      end
      default: return $urandom();
    endcase
  endfunction

  task send_run(logic [31:0] stamp, int len);
    for (int i = 0; i < len; i++)
      send_item(stamp);
  endtask

  initial begin
    logic [31:0] directed_stamps[$];
    logic [31:0] stamp;
    int          r;
    int          len;

    directed_stamps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                        32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h0000_0000,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
                        32'hF0F0_F0F0, 32'h0000_0002, 32'h0000_0002, 32'h0000_0003};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner stamps, repeats that will later form reclaim groups
    foreach (directed_stamps[i])
      send_item(directed_stamps[i]);

    // one long equal-stamp run: fills the pool, then reclaims the whole ring
    send_calm = 1'b1;
    send_run(32'hC0DE_0001, 520);
    send_calm = 1'b0;

    // random runs of equal stamps, singles as noise, occasional long runs
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        send_calm = !send_calm;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        stamp = pick_stamp();
        len   = $urandom_range(1, 8);
      end else if (r < 96) begin
        stamp = $urandom();
        len   = 1;
      end else begin
        stamp = pick_stamp();
        len   = $urandom_range(200, 300);
      end
      if (len > NUM_ITEMS - sent)
        len = NUM_ITEMS - sent;
      send_run(stamp, len);
    end
    in_valid <= 1'b0;

    // let the monitor note the last item, drain, then a short settle
    @(posedge clk);
    while (board.pending_grants.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    board.check_drained();

    if (board.error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
